/* design/ordered_list_insert_delete_unit_assert.svh */
// Assertion macros shared by the ordered list unit.
`ifndef ORDERED_LIST_INSERT_DELETE_UNIT_ASSERT_SVH
`define ORDERED_LIST_INSERT_DELETE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OLID_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define OLID_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/olid_pkg.sv */
// Package with operation codes, status codes and sizing defaults of the ordered list unit.
package olid_pkg;

  // Default number of list entries.
  localparam int DEPTH_DEFAULT = 8;

  // Operation codes.
  localparam logic [3:0] OP_INS_HEAD   = 4'd0;
  localparam logic [3:0] OP_INS_TAIL   = 4'd1;
  localparam logic [3:0] OP_DEL_HEAD   = 4'd2;
  localparam logic [3:0] OP_DEL_TAIL   = 4'd3;
  localparam logic [3:0] OP_INS_BEFORE = 4'd4;
  localparam logic [3:0] OP_INS_AFTER  = 4'd5;
  localparam logic [3:0] OP_DEL_BEFORE = 4'd6;
  localparam logic [3:0] OP_DEL_AFTER  = 4'd7;
  localparam logic [3:0] OP_SEARCH     = 4'd8;
  localparam logic [3:0] OP_DEL_VALUE  = 4'd9;
  localparam logic [3:0] OP_REPLACE    = 4'd10;
  localparam logic [3:0] OP_READ_AT    = 4'd11;

  // Status codes.
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_FULL        = 3'd1;
  localparam logic [2:0] ST_EMPTY       = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND   = 3'd3;
  localparam logic [2:0] ST_NO_NEIGHBOR = 3'd4;
  localparam logic [2:0] ST_RANGE       = 3'd5;

endpackage

/* design/ordered_list_insert_delete_unit.sv */
// Ordered list of signed 32-bit entries with shift insert and delete, run by a small sequencer.
//
//   channel | handshake             | fields
//   --------+-----------------------+-----------------------------------
//   in      | in_valid / in_ready   | opcode, key, value, index
//   out     | out_valid / out_ready | status, data, position, count
//
// Key operations scan the entry memory one entry at a time (read, then compare), and every
// shifted entry takes a read state and a write state on the memory.
// A beat passes through the scan, the shifts, a closing step for an insert or delete and a
// fetch for a read or an entry removed by place.
// Input is ready only in idle; a finished result is held until the output register is free.
// Reset empties the list at once; the entry memory itself is never cleared.
module ordered_list_insert_delete_unit
  import olid_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         opcode,
  input  logic signed [31:0] key,
  input  logic signed [31:0] value,
  input  logic [2:0]         index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         status,
  output logic signed [31:0] data,
  output logic [3:0]         position,
  output logic [3:0]         count
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CMP, S_EXEC, S_INS_RD, S_INS_WR,
    S_GET, S_GOT, S_DEL_RD, S_DEL_WR, S_DONE
  } state_t;

  state_t            state;
  logic [3:0]        op_code;
  logic [31:0]       match_key;
  logic [31:0]       new_value;
  logic [2:0]        read_index;
  logic [CW-1:0]     cnt;
  logic [CW-1:0]     ptr;
  logic [CW-1:0]     tgt;
  logic [CW-1:0]     pos;
  logic [31:0]       hit;
  logic [2:0]        res_status;
  logic [31:0]       res_data;

  // Entry memory with one write port and one registered read port.
  logic [31:0]       mem [DEPTH];
  logic [31:0]       rdata;
  logic [AW-1:0]     raddr;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [31:0]       mem_wd;

  logic              full;
  logic              empty;
  logic              key_op;

  assign in_ready = (state == S_IDLE);
  assign full     = (cnt == DEPTH_C);
  assign empty    = (cnt == '0);
  assign key_op   = (opcode >= OP_INS_BEFORE) && (opcode <= OP_REPLACE);

  // Read address: the insert shift reads the entry below, the delete shift the one above.
  always_comb begin
    unique case (state)
      S_INS_RD: raddr = AW'(ptr - ONE_C);
      S_DEL_RD: raddr = AW'(ptr + ONE_C);
      default:  raddr = AW'(ptr);
    endcase
  end

  // Write port selection.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = AW'(ptr);
    mem_wd = rdata;
    unique case (state)
      S_INS_RD: begin
        if (ptr == tgt) begin
          mem_we = 1'b1;
          mem_wd = new_value;
        end
      end
      S_INS_WR, S_DEL_WR: mem_we = 1'b1;
      S_EXEC: begin
        if (op_code == OP_REPLACE && !empty && pos != DEPTH_C) begin
          mem_we = 1'b1;
          mem_wa = AW'(pos);
          mem_wd = new_value;
        end
      end
      default: mem_we = 1'b0;
    endcase
  end

  // Memory array.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata <= mem[raddr];
  end

  // Sequencer, list state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_code    <= opcode;
            match_key  <= key;
            new_value  <= value;
            read_index <= index;
            res_status <= ST_OK;
            res_data   <= '0;
            pos        <= DEPTH_C;
            ptr        <= '0;
            if (key_op && !empty) begin
              state <= S_SCAN_RD;
            end else begin
              state <= S_EXEC;
            end
          end
        end

        S_SCAN_RD: state <= S_SCAN_CMP;

        // Compare one entry against the key; stop on the first match.
        S_SCAN_CMP: begin
          if (rdata == match_key) begin
            pos   <= ptr;
            hit   <= rdata;
            state <= S_EXEC;
          end else if (ptr + ONE_C == cnt) begin
            state <= S_EXEC;
          end else begin
            ptr   <= ptr + ONE_C;
            state <= S_SCAN_RD;
          end
        end

        // Check the operation and pick the shift or read that follows, or finish with its status.
        S_EXEC: begin
          unique case (op_code)
            OP_INS_HEAD, OP_INS_TAIL, OP_INS_BEFORE, OP_INS_AFTER: begin
              if (full) begin
                res_status <= ST_FULL;
                state      <= S_DONE;
              end else if ((op_code == OP_INS_BEFORE || op_code == OP_INS_AFTER)
                           && pos == DEPTH_C) begin
                res_status <= ST_NOT_FOUND;
                state      <= S_DONE;
              end else begin
                ptr   <= cnt;
                state <= S_INS_RD;
                unique case (op_code)
                  OP_INS_HEAD:   tgt <= '0;
                  OP_INS_TAIL:   tgt <= cnt;
                  OP_INS_BEFORE: tgt <= pos;
                  default:       tgt <= pos + ONE_C;
                endcase
              end
            end
            OP_DEL_HEAD, OP_DEL_TAIL: begin
              if (empty) begin
                res_status <= ST_EMPTY;
                state      <= S_DONE;
              end else begin
                ptr   <= (op_code == OP_DEL_HEAD) ? '0 : cnt - ONE_C;
                state <= S_GET;
              end
            end
            OP_DEL_BEFORE: begin
              if (empty) begin
                res_status <= ST_EMPTY;
                state      <= S_DONE;
              end else if (pos == DEPTH_C) begin
                res_status <= ST_NOT_FOUND;
                state      <= S_DONE;
              end else if (pos == '0) begin
                res_status <= ST_NO_NEIGHBOR;
                state      <= S_DONE;
              end else begin
                ptr   <= pos - ONE_C;
                state <= S_GET;
              end
            end
            OP_DEL_AFTER: begin
              if (empty) begin
                res_status <= ST_EMPTY;
                state      <= S_DONE;
              end else if (pos == DEPTH_C) begin
                res_status <= ST_NOT_FOUND;
                state      <= S_DONE;
              end else if (pos + ONE_C >= cnt) begin
                res_status <= ST_NO_NEIGHBOR;
                state      <= S_DONE;
              end else begin
                ptr   <= pos + ONE_C;
                state <= S_GET;
              end
            end
            OP_SEARCH, OP_DEL_VALUE, OP_REPLACE: begin
              if (empty) begin
                res_status <= ST_EMPTY;
                state      <= S_DONE;
              end else if (pos == DEPTH_C) begin
                res_status <= ST_NOT_FOUND;
                state      <= S_DONE;
              end else begin
                res_data <= hit;
                if (op_code == OP_DEL_VALUE) begin
                  ptr   <= pos;
                  state <= S_DEL_RD;
                end else begin
                  state <= S_DONE;
                end
              end
            end
            OP_READ_AT: begin
              if (32'(read_index) >= 32'(cnt)) begin
                res_status <= ST_RANGE;
                state      <= S_DONE;
              end else begin
                ptr   <= CW'(read_index);
                state <= S_GET;
              end
            end
            default: state <= S_DONE;
          endcase
        end

        // Insert: move entries up one place from the tail down to the target.
        S_INS_RD: begin
          if (ptr == tgt) begin
            cnt   <= cnt + ONE_C;
            state <= S_DONE;
          end else begin
            state <= S_INS_WR;
          end
        end

        S_INS_WR: begin
          ptr   <= ptr - ONE_C;
          state <= S_INS_RD;
        end

        // Fetch the entry that is read out or removed.
        S_GET: state <= S_GOT;

        S_GOT: begin
          res_data <= rdata;
          if (op_code == OP_READ_AT) begin
            state <= S_DONE;
          end else begin
            state <= S_DEL_RD;
          end
        end

        // Delete: move later entries down one place.
        S_DEL_RD: begin
          if (ptr + ONE_C >= cnt) begin
            cnt   <= cnt - ONE_C;
            state <= S_DONE;
          end else begin
            state <= S_DEL_WR;
          end
        end

        S_DEL_WR: begin
          ptr   <= ptr + ONE_C;
          state <= S_DEL_RD;
        end

        // Hand the result to the output register once it is free.
        S_DONE: begin
          if (!out_valid || out_ready) begin
            status    <= res_status;
            data      <= res_data;
            position  <= 4'(pos);
            count     <= 4'(cnt);
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

`include "ordered_list_insert_delete_unit_assert.svh"

  // The fill count never passes the capacity.
  `OLID_ASSERT_NOW(a_cnt_bound, 1'b1, cnt <= DEPTH_C, "fill count above capacity")

  // The fill count moves by at most one entry per cycle.
  `OLID_ASSERT_NEXT(a_cnt_step, 1'b1, (cnt == $past(cnt)) || (cnt == $past(cnt) + ONE_C) || (cnt + ONE_C == $past(cnt)), "fill count jumped")

  // An accepted beat keeps the sequencer busy in the following cycle.
  `OLID_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready right after accept")

  // A finished result waits while the previous one is still held in the output register.
  `OLID_ASSERT_NEXT(a_out_free, state == S_DONE && out_valid && !out_ready, state == S_DONE && out_valid, "result overwrite")

endmodule

/* sim/tb_ordered_list_insert_delete_unit.sv */
// Self-checking testbench for the ordered list unit with a list predictor and random traffic.
module tb_ordered_list_insert_delete_unit;
  import olid_pkg::*;

  localparam int DEPTH        = DEPTH_DEFAULT;
  localparam int RANDOM_OPS   = 1950;
  localparam int DRAIN_CYCLES = 4 * DEPTH + 40;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef struct packed {
    logic [3:0]         opcode;
    logic signed [31:0] key;
    logic signed [31:0] value;
    logic [2:0]         index;
  } list_cmd_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] data;
    logic [3:0]         position;
    logic [3:0]         count;
  } list_reply_t;

  typedef struct packed {
    logic [DEPTH-1:0][31:0] ent;
    logic [3:0]             cnt;
  } list_state_t;

  typedef struct packed {
    list_state_t nxt;
    list_reply_t res;
  } list_step_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [3:0]         opcode = OP_INS_HEAD;
  logic signed [31:0] key = '0;
  logic signed [31:0] value = '0;
  logic [2:0]         index = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         status;
  logic signed [31:0] data;
  logic [3:0]         position;
  logic [3:0]         count;

  list_cmd_t   pending_ops[$];
  list_reply_t expected_replies[$];
  list_state_t golden_list = '0;
  list_state_t plan_list = '0;
  list_cmd_t   cur_cmd = '0;
  int          errors = 0;
  int          cycles = 0;

  ordered_list_insert_delete_unit #(.DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .key(key), .value(value), .index(index),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .data(data), .position(position), .count(count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Opens a slot at position p and moves the later entries up by one.
  function automatic list_state_t shift_in(list_state_t s, int p, logic [31:0] v);
    int j;
    for (j = s.cnt; j > p; j--) s.ent[j] = s.ent[j-1];
    s.ent[p] = v;
    s.cnt = s.cnt + 4'd1;
    return s;
  endfunction

  // Removes the entry at position p and closes the hole.
  function automatic list_state_t shift_out(list_state_t s, int p);
    int j;
    for (j = p; j + 1 < s.cnt; j++) s.ent[j] = s.ent[j+1];
    s.cnt = s.cnt - 4'd1;
    return s;
  endfunction

  // Applies one list operation and gives the new list and the reply for that beat.
  function automatic list_step_t apply_list_op(list_state_t s, list_cmd_t c);
    list_step_t r;
    int         pos;
    int         cnt;
    int         i;
    bit         full;
    bit         empty;
    r.nxt = s;
    r.res.status = ST_OK;
    r.res.data = '0;
    cnt = s.cnt;
    full = cnt >= DEPTH;
    empty = cnt == 0;
    pos = DEPTH;
    // Key operations look for the first valid entry equal to the key.
    if (c.opcode >= OP_INS_BEFORE && c.opcode <= OP_REPLACE) begin
      for (i = cnt - 1; i >= 0; i--) if (s.ent[i] == c.key) pos = i;
    end
    case (c.opcode)
      OP_INS_HEAD: begin
        if (full) r.res.status = ST_FULL;
        else r.nxt = shift_in(s, 0, c.value);
      end
      OP_INS_TAIL: begin
        if (full) r.res.status = ST_FULL;
        else r.nxt = shift_in(s, cnt, c.value);
      end
      OP_DEL_HEAD: begin
        if (empty) r.res.status = ST_EMPTY;
        else begin
          r.res.data = s.ent[0];
          r.nxt = shift_out(s, 0);
        end
      end
      OP_DEL_TAIL: begin
        if (empty) r.res.status = ST_EMPTY;
        else begin
          r.res.data = s.ent[cnt-1];
          r.nxt = shift_out(s, cnt - 1);
        end
      end
      OP_INS_BEFORE, OP_INS_AFTER: begin
        if (full) r.res.status = ST_FULL;
        else if (pos >= DEPTH) r.res.status = ST_NOT_FOUND;
        else r.nxt = shift_in(s, (c.opcode == OP_INS_BEFORE) ? pos : pos + 1, c.value);
      end
      OP_DEL_BEFORE: begin
        if (empty) r.res.status = ST_EMPTY;
        else if (pos >= DEPTH) r.res.status = ST_NOT_FOUND;
        else if (pos == 0) r.res.status = ST_NO_NEIGHBOR;
        else begin
          r.res.data = s.ent[pos-1];
          r.nxt = shift_out(s, pos - 1);
        end
      end
      OP_DEL_AFTER: begin
        if (empty) r.res.status = ST_EMPTY;
        else if (pos >= DEPTH) r.res.status = ST_NOT_FOUND;
        else if (pos + 1 >= cnt) r.res.status = ST_NO_NEIGHBOR;
        else begin
          r.res.data = s.ent[pos+1];
          r.nxt = shift_out(s, pos + 1);
        end
      end
      OP_SEARCH: begin
        if (empty) r.res.status = ST_EMPTY;
        else if (pos >= DEPTH) r.res.status = ST_NOT_FOUND;
        else r.res.data = s.ent[pos];
      end
      OP_DEL_VALUE: begin
        if (empty) r.res.status = ST_EMPTY;
        else if (pos >= DEPTH) r.res.status = ST_NOT_FOUND;
        else begin
          r.res.data = s.ent[pos];
          r.nxt = shift_out(s, pos);
        end
      end
      OP_REPLACE: begin
        if (empty) r.res.status = ST_EMPTY;
        else if (pos >= DEPTH) r.res.status = ST_NOT_FOUND;
        else begin
          r.res.data = s.ent[pos];
          r.nxt.ent[pos] = c.value;
        end
      end
      OP_READ_AT: begin
        if (c.index >= cnt) r.res.status = ST_RANGE;
        else r.res.data = s.ent[c.index];
      end
      default: ;
    endcase
    r.res.position = 4'(pos);
    r.res.count = r.nxt.cnt;
    return r;
  endfunction

  // Queues one operation and tracks the list it leaves behind, so later keys can hit.
  task automatic plan_op(input logic [3:0] op, input logic signed [31:0] k,
                         input logic signed [31:0] v, input logic [2:0] idx);
    list_cmd_t  c;
    list_step_t stp;
    c.opcode = op;
    c.key = k;
    c.value = v;
    c.index = idx;
    stp = apply_list_op(plan_list, c);
    plan_list = stp.nxt;
    pending_ops.push_back(c);
  endtask

  // Draws a value: a small pool so duplicates show up, the two extremes, or any word.
  function automatic logic signed [31:0] draw_value();
    case ($urandom_range(0, 7))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2, 3, 4: return $urandom;
      default: return $signed($urandom_range(0, 8)) - 32'sd4;
    endcase
  endfunction

  // Sender: bursts of beats separated by random gaps, some stretches with no gaps.
  always @(posedge clk) begin : feed
    list_step_t stp;
    int         burst_left;
    int         gap_left;
    if (rst) begin
      in_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        stp = apply_list_op(golden_list, cur_cmd);
        golden_list = stp.nxt;
        expected_replies.push_back(stp.res);
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          cur_cmd = pending_ops.pop_front();
          opcode <= cur_cmd.opcode;
          key <= cur_cmd.key;
          value <= cur_cmd.value;
          index <= cur_cmd.index;
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 10);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: ready follows a 16-bit pattern that is redrawn now and then.
  always @(posedge clk) begin : drain
    logic [15:0] ready_pat;
    int          pat_left;
    logic [3:0]  pat_pos;
    if (rst) begin
      out_ready <= 1'b0;
      ready_pat = 16'hffff;
      pat_left = 0;
      pat_pos = '0;
    end else begin
      if (pat_left == 0) begin
        case ($urandom_range(0, 3))
          0:       ready_pat = 16'hffff;
          1:       ready_pat = 16'($urandom);
          2:       ready_pat = 16'($urandom & $urandom);
          default: ready_pat = 16'h5555 << $urandom_range(0, 1);
        endcase
        ready_pat[0] = 1'b1;
        pat_left = $urandom_range(16, 200);
      end else begin
        pat_left--;
      end
      out_ready <= ready_pat[pat_pos];
      pat_pos = pat_pos + 4'd1;
    end
  end

  // Checks every reply beat against the oldest expectation.
  always @(posedge clk) begin : check
    list_reply_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_replies.size() == 0) begin
        $display("%0t: unexpected reply status %0d data %0d position %0d count %0d",
                 $time, status, data, position, count);
        errors++;
      end else begin
        want = expected_replies.pop_front();
        if (status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status);
          errors++;
        end
        if (data !== want.data) begin
          $display("%0t: data expected %0d actual %0d", $time, want.data, data);
          errors++;
        end
        if (position !== want.position) begin
          $display("%0t: position expected %0d actual %0d", $time, want.position, position);
          errors++;
        end
        if (count !== want.count) begin
          $display("%0t: count expected %0d actual %0d", $time, want.count, count);
          errors++;
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_ordered_list_insert_delete_unit failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [3:0]         op;
    logic signed [31:0] k;
    int                 done_ops;
    int                 pick;
    int                 roll;
    bit                 filling;

    // Directed part: every operation except insert at head, at tail and after, on an empty list first.
    plan_op(OP_INS_BEFORE, 32'sd1, 32'sd2, 3'd0);
    plan_op(OP_DEL_HEAD, 32'sd0, 32'sd0, 3'd0);
    plan_op(OP_DEL_TAIL, 32'sd0, 32'sd0, 3'd0);
    plan_op(OP_DEL_BEFORE, 32'sd0, 32'sd0, 3'd0);
    plan_op(OP_DEL_AFTER, 32'sd0, 32'sd0, 3'd0);
    plan_op(OP_SEARCH, 32'sd0, 32'sd0, 3'd0);
    plan_op(OP_DEL_VALUE, 32'sd0, 32'sd0, 3'd0);
    plan_op(OP_REPLACE, 32'sd0, 32'sd1, 3'd0);
    plan_op(OP_READ_AT, 32'sd0, 32'sd0, 3'd0);
    // Fill with the extremes, then hit the neighbor and full-list corners.
    plan_op(OP_INS_TAIL, 32'sd0, 32'sh8000_0000, 3'd0);
    plan_op(OP_INS_TAIL, 32'sd0, 32'sh7fff_ffff, 3'd0);
    plan_op(OP_INS_HEAD, 32'sd0, -32'sd1, 3'd0);
    plan_op(OP_INS_HEAD, 32'sd0, 32'sd0, 3'd0);
    plan_op(OP_INS_BEFORE, 32'sd0, 32'sd5, 3'd0);
    plan_op(OP_DEL_BEFORE, 32'sd5, 32'sd0, 3'd0);
    plan_op(OP_DEL_AFTER, 32'sh7fff_ffff, 32'sd0, 3'd0);
    plan_op(OP_INS_AFTER, 32'sh7fff_ffff, 32'sd7, 3'd0);
    plan_op(OP_INS_AFTER, 32'sh8000_0000, 32'sh8000_0000, 3'd0);
    plan_op(OP_INS_BEFORE, -32'sd1, -32'sd1, 3'd0);
    plan_op(OP_INS_TAIL, 32'sd0, 32'sd3, 3'd0);
    plan_op(OP_INS_BEFORE, 32'sd12345, 32'sd3, 3'd0);
    plan_op(OP_SEARCH, 32'sh8000_0000, 32'sd0, 3'd0);
    plan_op(OP_READ_AT, 32'sd0, 32'sd0, 3'd7);
    plan_op(OP_DEL_AFTER, 32'sh8000_0000, 32'sd0, 3'd0);
    plan_op(OP_DEL_BEFORE, 32'sd0, 32'sd0, 3'd0);
    plan_op(OP_REPLACE, -32'sd1, 32'sh7fff_ffff, 3'd0);
    plan_op(OP_READ_AT, 32'sd0, 32'sd0, 3'd6);
    plan_op(OP_SEARCH, 32'sd999, 32'sd0, 3'd0);
    plan_op(4'd15, 32'sd0, 32'sd0, 3'd0);

    // Random part: sweeps the list between empty and full, with keys mostly taken
    // from the current contents so the key operations find their match.
    done_ops = 0;
    filling = 1'b1;
    while (done_ops < RANDOM_OPS) begin
      if (plan_list.cnt == DEPTH) filling = 1'b0;
      else if (plan_list.cnt == 0) filling = 1'b1;
      else if ($urandom_range(0, 49) == 0) filling = !filling;
      if (plan_list.cnt > 0 && $urandom_range(0, 9) < 8) begin
        pick = $urandom_range(0, plan_list.cnt - 1);
        k = plan_list.ent[pick];
      end else begin
        k = draw_value();
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        // Unused opcodes only leave the list alone.
        op = 4'($urandom_range(12, 15));
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 25) begin
          case ($urandom_range(0, 2))
            0:       op = OP_SEARCH;
            1:       op = OP_REPLACE;
            default: op = OP_READ_AT;
          endcase
        end else if (filling ? roll < 75 : roll < 40) begin
          case ($urandom_range(0, 3))
            0:       op = OP_INS_HEAD;
            1:       op = OP_INS_TAIL;
            2:       op = OP_INS_BEFORE;
            default: op = OP_INS_AFTER;
          endcase
        end else begin
          case ($urandom_range(0, 4))
            0:       op = OP_DEL_HEAD;
            1:       op = OP_DEL_TAIL;
            2:       op = OP_DEL_BEFORE;
            3:       op = OP_DEL_AFTER;
            default: op = OP_DEL_VALUE;
          endcase
        end
        done_ops++;
      end
      plan_op(op, k, draw_value(), 3'($urandom_range(0, 7)));
    end

    // Hold reset, then release it on a clock edge.
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Wait until every beat has gone in and every reply has come back.
    while (pending_ops.size() != 0 || in_valid || expected_replies.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("tb_ordered_list_insert_delete_unit passed");
    else
      $display("tb_ordered_list_insert_delete_unit failed");
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/olid_pkg.sv
design/ordered_list_insert_delete_unit.sv
sim/tb_ordered_list_insert_delete_unit.sv
